FILE: hw/rtl/swbm_pkg.sv
// package for the single-wire bus master: codes, register defaults, shared types
// no dependencies; used by every module of the block
package swbm_pkg;

    localparam int DEFAULT_FRAME_BITS = 9;
    localparam int TICK_W             = 12;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 12;
    localparam int S_TDATA_W          = 16;
    localparam int S_TUSER_W          = 2;
    localparam int M_TDATA_W          = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_DRIVE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_SAMPLE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_LOW       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_HIGH      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_RECOVER = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DISCOVERY_LOW = 3'd6;

    // register reset values
    localparam logic [7:0]        RST_BIT_DRIVE     = 8'd1;
    localparam logic [7:0]        RST_BIT_SAMPLE    = 8'd2;
    localparam logic [7:0]        RST_BIT_LOW       = 8'd6;
    localparam logic [7:0]        RST_BIT_HIGH      = 8'd11;
    localparam logic [TICK_W-1:0] RST_RESET_LOW     = 12'd200;
    localparam logic [TICK_W-1:0] RST_RESET_RECOVER = 12'd16;
    localparam logic [7:0]        RST_DISCOVERY_LOW = 8'd1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_BYTE  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_BYTE  = 3'b010,
        MODE_RESET = 3'b100
    } mode_t;

    localparam logic [1:0] PH_ACTIVE    = 2'd0;
    localparam logic [1:0] PH_RECOVER   = 2'd1;
    localparam logic [1:0] PH_DISCOVERY = 2'd2;

    typedef struct packed {
        logic [7:0]        bit_drive_ticks;
        logic [7:0]        bit_sample_tick;
        logic [7:0]        bit_low_ticks;
        logic [7:0]        bit_high_ticks;
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] reset_recover_ticks;
        logic [7:0]        discovery_low_ticks;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_high;
    } result_t;

endpackage

FILE: hw/rtl/swbm_cfg_regs.sv
// configuration register file of the single-wire bus master
// depends on swbm_pkg
module swbm_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [swbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [swbm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output swbm_pkg::cfg_t                       cfg
);

    swbm_pkg::cfg_t cfg_reg;
    swbm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                swbm_pkg::REG_BIT_DRIVE:     cfg_next.bit_drive_ticks     = cfg_data[7:0];
                swbm_pkg::REG_BIT_SAMPLE:    cfg_next.bit_sample_tick     = cfg_data[7:0];
                swbm_pkg::REG_BIT_LOW:       cfg_next.bit_low_ticks       = cfg_data[7:0];
                swbm_pkg::REG_BIT_HIGH:      cfg_next.bit_high_ticks      = cfg_data[7:0];
                swbm_pkg::REG_RESET_LOW:     cfg_next.reset_low_ticks     = cfg_data;
                swbm_pkg::REG_RESET_RECOVER: cfg_next.reset_recover_ticks = cfg_data;
                swbm_pkg::REG_DISCOVERY_LOW: cfg_next.discovery_low_ticks = cfg_data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_drive_ticks     <= swbm_pkg::RST_BIT_DRIVE;
            cfg_reg.bit_sample_tick     <= swbm_pkg::RST_BIT_SAMPLE;
            cfg_reg.bit_low_ticks       <= swbm_pkg::RST_BIT_LOW;
            cfg_reg.bit_high_ticks      <= swbm_pkg::RST_BIT_HIGH;
            cfg_reg.reset_low_ticks     <= swbm_pkg::RST_RESET_LOW;
            cfg_reg.reset_recover_ticks <= swbm_pkg::RST_RESET_RECOVER;
            cfg_reg.discovery_low_ticks <= swbm_pkg::RST_DISCOVERY_LOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/swbm_core.sv
// bus state machine: mode, bit frame, slot phase and tick counter, one step per item
// depends on swbm_pkg
module swbm_core
#(
    parameter int FRAME_BITS = swbm_pkg::DEFAULT_FRAME_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [1:0]           action,
    input  logic [7:0]           tx_byte,
    input  logic                 release_ack,
    input  logic                 line_level,
    input  swbm_pkg::cfg_t       cfg,
    output swbm_pkg::result_t    result
);

    localparam int IDX_W  = $clog2(FRAME_BITS);
    localparam int BL_W   = $clog2(FRAME_BITS + 1);
    localparam int WIDE_W = FRAME_BITS + 9;
    localparam int TW     = swbm_pkg::TICK_W;

    swbm_pkg::mode_t         mode_reg, mode_next;
    logic [FRAME_BITS-1:0]   shift_reg, shift_next;
    logic [BL_W-1:0]         bits_left_reg, bits_left_next;
    logic [1:0]              phase_reg, phase_next;
    logic [TW-1:0]           tick_reg, tick_next;

    logic [TW:0]             n;
    logic [BL_W-1:0]         bl_dec;
    logic [IDX_W-1:0]        idx;
    logic                    bitv;
    logic [TW-1:0]           part_len;
    logic                    part_end;
    logic [TW-1:0]           tick_after;
    logic [WIDE_W-1:0]       load_wide;
    logic [WIDE_W-1:0]       shift_wide;
    logic                    drive;
    logic                    done;
    logic [7:0]              rx;
    logic                    ack;

    always_comb
    begin
        n          = {1'b0, tick_reg} + {{TW{1'b0}}, 1'b1};
        bl_dec     = bits_left_reg - {{(BL_W-1){1'b0}}, 1'b1};
        idx        = (bits_left_reg == '0) ? '0 : bl_dec[IDX_W-1:0];
        bitv       = shift_reg[idx];
        load_wide  = {{FRAME_BITS{1'b0}}, tx_byte, release_ack};
        shift_wide = {9'd0, shift_reg};

        if (mode_reg == swbm_pkg::MODE_BYTE)
        begin
            part_len = (phase_reg == swbm_pkg::PH_ACTIVE) ?
                       {4'd0, cfg.bit_low_ticks} : {4'd0, cfg.bit_high_ticks};
        end
        else
        begin
            priority case (phase_reg)
                swbm_pkg::PH_ACTIVE:  part_len = cfg.reset_low_ticks;
                swbm_pkg::PH_RECOVER: part_len = cfg.reset_recover_ticks;
                default:              part_len = {4'd0, cfg.discovery_low_ticks};
            endcase
        end
        part_end   = (n >= {1'b0, part_len});
        tick_after = part_end ? '0 : n[TW-1:0];
    end

    always_comb
    begin
        mode_next      = mode_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        drive          = 1'b0;
        done           = 1'b0;
        rx             = 8'd0;
        ack            = 1'b0;

        unique case (swbm_pkg::action_t'(action))
            swbm_pkg::ACT_RESET, swbm_pkg::ACT_BYTE:
            begin
                if (mode_reg == swbm_pkg::MODE_IDLE)
                begin
                    phase_next = swbm_pkg::PH_ACTIVE;
                    tick_next  = '0;
                    if (action == swbm_pkg::ACT_RESET)
                    begin
                        mode_next = swbm_pkg::MODE_RESET;
                    end
                    else
                    begin
                        mode_next      = swbm_pkg::MODE_BYTE;
                        shift_next     = load_wide[FRAME_BITS-1:0];
                        bits_left_next = BL_W'(FRAME_BITS);
                    end
                end
            end
            swbm_pkg::ACT_TICK:
            begin
                unique case (mode_reg)
                    swbm_pkg::MODE_BYTE:
                    begin
                        tick_next = tick_after;
                        if (phase_reg == swbm_pkg::PH_ACTIVE)
                        begin
                            if (bitv)
                            begin
                                drive = (cfg.bit_drive_ticks != 8'd0) &&
                                        ((n <= {5'd0, cfg.bit_drive_ticks}) ||
                                         (n <= {{TW{1'b0}}, 1'b1}));
                            end
                            else
                            begin
                                drive = 1'b1;
                            end
                            if ((n == {5'd0, cfg.bit_sample_tick}) && !line_level)
                            begin
                                shift_next = shift_reg &
                                             ~({{(FRAME_BITS-1){1'b0}}, 1'b1} << idx);
                            end
                            if (part_end)
                            begin
                                if (bits_left_reg != '0)
                                begin
                                    bits_left_next = bl_dec;
                                end
                                phase_next = swbm_pkg::PH_RECOVER;
                            end
                        end
                        else if (part_end)
                        begin
                            phase_next = swbm_pkg::PH_ACTIVE;
                            if (bits_left_reg == '0)
                            begin
                                mode_next = swbm_pkg::MODE_IDLE;
                                done      = 1'b1;
                                rx        = shift_wide[8:1];
                                ack       = shift_wide[0];
                            end
                        end
                    end
                    swbm_pkg::MODE_RESET:
                    begin
                        tick_next = tick_after;
                        priority case (phase_reg)
                            swbm_pkg::PH_ACTIVE:
                            begin
                                drive = 1'b1;
                                if (part_end)
                                begin
                                    phase_next = swbm_pkg::PH_RECOVER;
                                end
                            end
                            swbm_pkg::PH_RECOVER:
                            begin
                                if (part_end)
                                begin
                                    phase_next = swbm_pkg::PH_DISCOVERY;
                                end
                            end
                            default:
                            begin
                                drive = 1'b1;
                                if (part_end)
                                begin
                                    phase_next = swbm_pkg::PH_ACTIVE;
                                    mode_next  = swbm_pkg::MODE_IDLE;
                                    done       = 1'b1;
                                end
                            end
                        endcase
                    end
                    default:
                    begin
                        mode_next = swbm_pkg::MODE_IDLE;
                    end
                endcase
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        result.drive_low = drive;
        result.busy_res  = (mode_next == swbm_pkg::MODE_BYTE) ||
                           (mode_next == swbm_pkg::MODE_RESET);
        result.done_res  = done;
        result.rx_byte   = rx;
        result.ack_high  = ack;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= swbm_pkg::MODE_IDLE;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            phase_reg     <= swbm_pkg::PH_ACTIVE;
            tick_reg      <= '0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
        end
    end

endmodule

FILE: hw/rtl/single_wire_bus_master_unit.sv
// Single-wire bus master, top level: input register, bus state machine, result register.
// Each item on the slave stream is a time-base tick or a command; one result item per item.
// The stream carries action in s_tuser; command and line data in s_tdata.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the slot and reset timing;
// cfg_ready is always high, and writes are meant for when no item is in flight.
// Register indexes: 0 bit drive, 1 bit sample, 2 bit low, 3 bit high, 4 reset low,
// 5 reset recover, 6 discovery low; other indexes are ignored.
// Path: an accepted item is held in the input register, and its result leaves on
// m_tdata from the result register.
// Throughput: one item per cycle while m_tready stays high; the single state-machine step
// between the two registers updates mode, frame, slot phase and tick counter in that same cycle.
// When m_tready is low the result register holds, the input register still takes
// one more item, and s_tready then drops until the result is taken.
// Reset (rst_n low) empties both registers, puts the bus idle with the line released
// and loads the default timing values.
module single_wire_bus_master_unit
#(
    parameter int FRAME_BITS = swbm_pkg::DEFAULT_FRAME_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tx_byte [7:0], release_ack [8], line_level [9], zero [15:10]
    input  logic [swbm_pkg::S_TDATA_W-1:0]       s_tdata,
    // action [1:0]
    input  logic [swbm_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // drive_low [0], busy_res [1], done_res [2], rx_byte [10:3], ack_high [11], zero [15:12]
    output logic [swbm_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [swbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                 in_valid_reg;
    logic [1:0]           act_reg;
    logic [7:0]           tx_reg;
    logic                 rel_reg;
    logic                 line_reg;
    logic                 out_valid_reg;
    swbm_pkg::result_t    out_reg;
    swbm_pkg::result_t    result;
    swbm_pkg::cfg_t       cfg;
    logic                 advance;
    logic                 take_in;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign take_in   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    swbm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swbm_core #(.FRAME_BITS(FRAME_BITS)) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .action      (act_reg),
        .tx_byte     (tx_reg),
        .release_ack (rel_reg),
        .line_level  (line_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            act_reg  <= s_tuser[1:0];
            tx_reg   <= s_tdata[7:0];
            rel_reg  <= s_tdata[8];
            line_reg <= s_tdata[9];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.ack_high, out_reg.rx_byte, out_reg.done_res,
                       out_reg.busy_res, out_reg.drive_low};

endmodule

FILE: hw/rtl/swbm_checker.sv
// port-level checks for the single-wire bus master, bound to the top level
// depends on swbm_pkg and single_wire_bus_master_unit
module swbm_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [swbm_pkg::M_TDATA_W-1:0]       m_tdata
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // finishing returns the bus to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("done reported while still busy");

    // read-back fields only with done
    a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> (m_tdata[11:3] == 9'd0))
        else $error("read-back data without done");

    // line is pulled only during an operation
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[1] || m_tdata[2]))
        else $error("line driven low while idle");

endmodule

bind single_wire_bus_master_unit swbm_checker u_swbm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for single_wire_bus_master_unit: random and directed tick/command
// streams with random stalls on both sides, results checked against an item-level predictor
// depends on swbm_pkg and the single_wire_bus_master_unit rtl only
module tb_top;

    localparam int          FRAME           = swbm_pkg::DEFAULT_FRAME_BITS;
    localparam logic [15:0] FRAME_MASK      = 16'((1 << FRAME) - 1);
    localparam logic [1:0]  ACT_UNKNOWN     = 2'd3;
    localparam logic [2:0]  REG_UNUSED      = 3'd7;
    localparam int          HOLD_OFF_AT     = 400;
    localparam int          HOLD_OFF_CYCLES = 60;
    localparam int          STALL_LIMIT     = 1000;

    class bus_master_scoreboard;
        swbm_pkg::cfg_t    timing;
        swbm_pkg::mode_t   mode;
        logic [15:0]       frame;
        logic [4:0]        bits_left;
        logic [1:0]        phase;
        logic [11:0]       ticks;
        swbm_pkg::result_t expected_q[$];
        int                errors;
        int                checked;
        int                bytes_done;
        int                resets_done;

        function new();
            timing = '{swbm_pkg::RST_BIT_DRIVE, swbm_pkg::RST_BIT_SAMPLE,
                       swbm_pkg::RST_BIT_LOW, swbm_pkg::RST_BIT_HIGH,
                       swbm_pkg::RST_RESET_LOW, swbm_pkg::RST_RESET_RECOVER,
                       swbm_pkg::RST_DISCOVERY_LOW};
            mode        = swbm_pkg::MODE_IDLE;
            frame       = '0;
            bits_left   = '0;
            phase       = swbm_pkg::PH_ACTIVE;
            ticks       = '0;
            errors      = 0;
            checked     = 0;
            bytes_done  = 0;
            resets_done = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [11:0] data);
            case (idx)
                swbm_pkg::REG_BIT_DRIVE:     timing.bit_drive_ticks     = data[7:0];
                swbm_pkg::REG_BIT_SAMPLE:    timing.bit_sample_tick     = data[7:0];
                swbm_pkg::REG_BIT_LOW:       timing.bit_low_ticks       = data[7:0];
                swbm_pkg::REG_BIT_HIGH:      timing.bit_high_ticks      = data[7:0];
                swbm_pkg::REG_RESET_LOW:     timing.reset_low_ticks     = data;
                swbm_pkg::REG_RESET_RECOVER: timing.reset_recover_ticks = data;
                swbm_pkg::REG_DISCOVERY_LOW: timing.discovery_low_ticks = data[7:0];
                default: ;
            endcase
        endfunction

        // advance the tick counter; true on the last tick of a part of length len
        function bit part_over(int len);
            int n;
            n = ticks + 1;
            if (n >= len)
            begin
                ticks = '0;
                return 1'b1;
            end
            ticks = n[11:0];
            return 1'b0;
        endfunction

        function void note_item(logic [1:0] act, logic [7:0] tx, logic rel, logic line);
            swbm_pkg::result_t r;
            int                idx;
            int                n;
            logic              bitv;
            r = '0;
            if (act == swbm_pkg::ACT_RESET || act == swbm_pkg::ACT_BYTE)
            begin
                if (mode == swbm_pkg::MODE_IDLE)
                begin
                    phase = swbm_pkg::PH_ACTIVE;
                    ticks = '0;
                    if (act == swbm_pkg::ACT_RESET)
                        mode = swbm_pkg::MODE_RESET;
                    else
                    begin
                        mode      = swbm_pkg::MODE_BYTE;
                        frame     = {7'b0, tx, rel} & FRAME_MASK;
                        bits_left = 5'(FRAME);
                    end
                end
            end
            else if (act == swbm_pkg::ACT_TICK)
            begin
                if (mode == swbm_pkg::MODE_BYTE)
                begin
                    if (phase == swbm_pkg::PH_ACTIVE)
                    begin
                        idx  = ((bits_left == 0) ? 0 : bits_left - 1) & 15;
                        bitv = frame[idx];
                        n    = ticks + 1;
                        r.drive_low = bitv ? (n <= timing.bit_drive_ticks || n <= 1) : 1'b1;
                        if (bitv && timing.bit_drive_ticks == 0)
                            r.drive_low = 1'b0;
                        if (n == timing.bit_sample_tick && !line)
                            frame[idx] = 1'b0;
                        if (part_over(timing.bit_low_ticks))
                        begin
                            if (bits_left > 0)
                                bits_left = bits_left - 1'b1;
                            phase = swbm_pkg::PH_RECOVER;
                        end
                    end
                    else if (part_over(timing.bit_high_ticks))
                    begin
                        phase = swbm_pkg::PH_ACTIVE;
                        if (bits_left == 0)
                        begin
                            mode       = swbm_pkg::MODE_IDLE;
                            r.done_res = 1'b1;
                            r.rx_byte  = frame[8:1];
                            r.ack_high = frame[0];
                            bytes_done++;
                        end
                    end
                end
                else if (mode == swbm_pkg::MODE_RESET)
                begin
                    if (phase == swbm_pkg::PH_ACTIVE)
                    begin
                        r.drive_low = 1'b1;
                        if (part_over(timing.reset_low_ticks))
                            phase = swbm_pkg::PH_RECOVER;
                    end
                    else if (phase == swbm_pkg::PH_RECOVER)
                    begin
                        if (part_over(timing.reset_recover_ticks))
                            phase = swbm_pkg::PH_DISCOVERY;
                    end
                    else
                    begin
                        r.drive_low = 1'b1;
                        if (part_over(timing.discovery_low_ticks))
                        begin
                            phase      = swbm_pkg::PH_ACTIVE;
                            mode       = swbm_pkg::MODE_IDLE;
                            r.done_res = 1'b1;
                            resets_done++;
                        end
                    end
                end
            end
            r.busy_res = (mode != swbm_pkg::MODE_IDLE);
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] mismatch on result %0d: %s got %0h want %0h",
                     $time, checked, what, got, want);
            errors++;
        endtask

        task check_result(logic [15:0] data);
            swbm_pkg::result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected item", data, 0);
                return;
            end
            want = expected_q.pop_front();
            if (data[0] !== want.drive_low)
                report_mismatch("drive_low", data[0], want.drive_low);
            if (data[1] !== want.busy_res)
                report_mismatch("busy_res", data[1], want.busy_res);
            if (data[2] !== want.done_res)
                report_mismatch("done_res", data[2], want.done_res);
            if (data[10:3] !== want.rx_byte)
                report_mismatch("rx_byte", data[10:3], want.rx_byte);
            if (data[11] !== want.ack_high)
                report_mismatch("ack_high", data[11], want.ack_high);
        endtask
    endclass

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [swbm_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [swbm_pkg::S_TUSER_W-1:0]   s_tuser   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [swbm_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [swbm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [swbm_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    bus_master_scoreboard sb = new();
    int items_sent   = 0;
    int calm_in      = 0;
    int calm_out     = 0;
    int settings     = 1;
    int stall_cycles = 0;

    single_wire_bus_master_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // random gap per item, with occasional stretches of back-to-back items
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic logic line_sense();
        return $urandom_range(0, 3) != 0;
    endfunction

    function automatic int byte_ticks();
        return FRAME * (sb.timing.bit_low_ticks + sb.timing.bit_high_ticks);
    endfunction

    function automatic int reset_ticks();
        return sb.timing.reset_low_ticks + sb.timing.reset_recover_ticks
               + sb.timing.discovery_low_ticks;
    endfunction

    function automatic swbm_pkg::cfg_t make_timing(int drv, int smp, int low, int high,
                                                   int rlow, int rrec, int disc);
        swbm_pkg::cfg_t t;
        t.bit_drive_ticks     = drv[7:0];
        t.bit_sample_tick     = smp[7:0];
        t.bit_low_ticks       = low[7:0];
        t.bit_high_ticks      = high[7:0];
        t.reset_low_ticks     = rlow[11:0];
        t.reset_recover_ticks = rrec[11:0];
        t.discovery_low_ticks = disc[7:0];
        return t;
    endfunction

    function automatic swbm_pkg::cfg_t random_timing();
        int low;
        low = $urandom_range(1, 6);
        return make_timing($urandom_range(1, low + 1), $urandom_range(1, low + 2), low,
                           $urandom_range(1, 4), $urandom_range(1, 10),
                           $urandom_range(1, 8), $urandom_range(1, 4));
    endfunction

    task automatic send_item(logic [1:0] act, logic [7:0] tx, logic rel, logic line);
        int gap;
        gap = draw_gap(calm_in);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, line, rel, tx};
        do @(posedge clk); while (!s_tready);
        sb.note_item(act, tx, rel, line);
        items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // 8-bit registers get random upper bits, which must be dropped
    task automatic program_timing(swbm_pkg::cfg_t t);
        write_reg(swbm_pkg::REG_BIT_DRIVE,
                  {4'($urandom_range(0, 15)), t.bit_drive_ticks});
        write_reg(swbm_pkg::REG_BIT_SAMPLE,
                  {4'($urandom_range(0, 15)), t.bit_sample_tick});
        write_reg(swbm_pkg::REG_BIT_LOW,
                  {4'($urandom_range(0, 15)), t.bit_low_ticks});
        write_reg(swbm_pkg::REG_BIT_HIGH,
                  {4'($urandom_range(0, 15)), t.bit_high_ticks});
        write_reg(swbm_pkg::REG_RESET_LOW,     t.reset_low_ticks);
        write_reg(swbm_pkg::REG_RESET_RECOVER, t.reset_recover_ticks);
        write_reg(swbm_pkg::REG_DISCOVERY_LOW,
                  {4'($urandom_range(0, 15)), t.discovery_low_ticks});
        write_reg(REG_UNUSED, 12'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), line_sense());
    endtask

    // command followed by n ticks, with stray random items mixed in while busy
    task automatic run_op(logic [1:0] act, int n);
        send_item(act, 8'($urandom), 1'($urandom), line_sense());
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_noise();
            send_item(swbm_pkg::ACT_TICK, 8'($urandom), 1'($urandom), line_sense());
        end
    endtask

    task automatic run_traffic(int count);
        int   first;
        int   len;
        logic is_byte;
        first = items_sent;
        while (items_sent - first < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                is_byte = $urandom_range(0, 2) != 0;
                len = is_byte ? byte_ticks() : reset_ticks();
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(0, len - 1);
                run_op(is_byte ? swbm_pkg::ACT_BYTE : swbm_pkg::ACT_RESET, len);
            end
            else
                send_noise();
        end
        // enough plain ticks to finish whatever is still running
        len = (byte_ticks() > reset_ticks()) ? byte_ticks() : reset_ticks();
        for (int k = 0; k < len; k++)
            send_item(swbm_pkg::ACT_TICK, 8'($urandom), 1'($urandom), line_sense());
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int gap;
        bit held_off;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held_off && sb.checked >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                gap = HOLD_OFF_CYCLES;
            end
            else
                gap = draw_gap(calm_out);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default timing straight out of reset
        run_traffic(100);
        settle();

        // shortest timing, with the hand-made cases first
        program_timing(make_timing(1, 1, 1, 1, 1, 1, 1));
        send_item(ACT_UNKNOWN, 8'hFF, 1'b1, 1'b0);
        send_item(swbm_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1);
        send_item(swbm_pkg::ACT_BYTE, 8'hFF, 1'b1, 1'b0);
        send_item(swbm_pkg::ACT_BYTE, 8'h00, 1'b0, 1'b1);
        send_item(swbm_pkg::ACT_RESET, 8'h5A, 1'b0, 1'b1);
        send_item(ACT_UNKNOWN, 8'h00, 1'b0, 1'b1);
        for (int k = 0; k < 2 * FRAME; k++)
            send_item(swbm_pkg::ACT_TICK, 8'h00, 1'b0, (k % 4) < 2);
        send_item(swbm_pkg::ACT_RESET, 8'h00, 1'b1, 1'b0);
        for (int k = 0; k < 3; k++)
            send_item(swbm_pkg::ACT_TICK, 8'hFF, 1'b1, 1'b0);
        run_traffic(120);
        settle();

        // sample after the active part, one bits held low throughout
        program_timing(make_timing(255, 255, 3, 2, 1, 1, 40));
        run_traffic(150);
        settle();

        for (int p = 0; p < 3; p++)
        begin
            program_timing(random_timing());
            run_traffic(120);
            settle();
        end

        // reset low length past eight bits: one exchange and one bus reset
        program_timing(make_timing(3, 5, 8, 4, 257, 3, 2));
        run_op(swbm_pkg::ACT_BYTE, byte_ticks());
        run_op(swbm_pkg::ACT_RESET, reset_ticks());
        settle();

        $display("%0d items over %0d timing settings, %0d results checked",
                 items_sent, settings, sb.checked);
        $display("%0d byte exchanges and %0d bus resets completed, %0d mismatches",
                 sb.bytes_done, sb.resets_done, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
